>>> hw/rtl/gdb_pkg.sv
// Shared types, constants and the month offset table for the date difference pipeline.
// No dependencies.
package gdb_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int LEAP_W  = 12;   // leap years below a 14-bit year, max 3973
  localparam int DOY_W   = 9;    // day of year incl. months 13..15, max 397
  localparam int SMALL_W = 14;   // signed sum of leap and day-of-year differences
  localparam int YD365_W = 23;   // 365 * year span, unsigned
  localparam int TOTAL_W = 25;
  localparam int COUNT_W = 23;
  localparam int PROD_W  = 27;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for every 14-bit x
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam int          QUOT_W       = 8;
  localparam logic [YEAR_W-1:0] CENT   = 14'd100;
  localparam logic [YD365_W-1:0] YEAR_DAYS = 23'd365;

  localparam logic signed [TOTAL_W-1:0] DC_MAX = 25'sd4194303;
  localparam logic signed [TOTAL_W-1:0] DC_MIN = -25'sd4194304;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [LEAP_W-1:0]  leaps_t;
  typedef logic [DOY_W-1:0]   doy_t;
  typedef logic signed [COUNT_W-1:0] count_t;

  // days in the months before m, common year; 13..15 cover the whole year
  function automatic doy_t month_offset(input month_t m);
    doy_t r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/gdb_date_unit.sv
// Two-stage per-date unit: leap years below the year and day of year.
// Depends on gdb_pkg.
module gdb_date_unit (
  input  logic            clk,
  input  logic            en,
  input  gdb_pkg::year_t  year,
  input  gdb_pkg::month_t month,
  input  gdb_pkg::day_t   day,
  output gdb_pkg::leaps_t leaps,
  output gdb_pkg::doy_t   doy
);

  // stage A: reciprocal products
  gdb_pkg::year_t  y_r;
  gdb_pkg::month_t m_r;
  gdb_pkg::day_t   d_r;
  logic            yz_r;
  logic [gdb_pkg::PROD_W-1:0] pa_r, pa_nxt;
  logic [gdb_pkg::PROD_W-1:0] py_r, py_nxt;

  // stage B results
  gdb_pkg::leaps_t leaps_r, leaps_nxt;
  gdb_pkg::doy_t   doy_r, doy_nxt;

  gdb_pkg::year_t  a_in;
  gdb_pkg::year_t  a_b;
  gdb_pkg::year_t  rem_y;
  logic [gdb_pkg::QUOT_W-1:0] qa, qy;
  logic [gdb_pkg::LEAP_W:0]   lsum;
  logic            leap;

  assign a_in   = year - gdb_pkg::year_t'(1);
  assign pa_nxt = gdb_pkg::PROD_W'(a_in) * gdb_pkg::PROD_W'(gdb_pkg::DIV100_MUL);
  assign py_nxt = gdb_pkg::PROD_W'(year) * gdb_pkg::PROD_W'(gdb_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      y_r  <= year;
      m_r  <= month;
      d_r  <= day;
      yz_r <= (year == '0);
      pa_r <= pa_nxt;
      py_r <= py_nxt;
    end
  end

  // leaps in [0, y) = 1 + (y-1)/4 - (y-1)/100 + (y-1)/400 for y >= 1, else 0
  always_comb begin
    a_b   = y_r - gdb_pkg::year_t'(1);
    qa    = pa_r[gdb_pkg::DIV100_SHIFT +: gdb_pkg::QUOT_W];
    qy    = py_r[gdb_pkg::DIV100_SHIFT +: gdb_pkg::QUOT_W];
    lsum  = (gdb_pkg::LEAP_W+1)'(1) + (gdb_pkg::LEAP_W+1)'(a_b[gdb_pkg::YEAR_W-1:2])
          - (gdb_pkg::LEAP_W+1)'(qa) + (gdb_pkg::LEAP_W+1)'(qa[gdb_pkg::QUOT_W-1:2]);
    leaps_nxt = yz_r ? '0 : lsum[gdb_pkg::LEAP_W-1:0];
    rem_y = y_r - gdb_pkg::year_t'(qy) * gdb_pkg::CENT;
    leap  = (y_r[1:0] == 2'b00) && ((rem_y != '0) || (qy[1:0] == 2'b00));
    doy_nxt = gdb_pkg::doy_t'(d_r) + gdb_pkg::month_offset(m_r)
            + gdb_pkg::doy_t'(leap && (m_r >= 4'd3));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      leaps_r <= leaps_nxt;
      doy_r   <= doy_nxt;
    end
  end

  assign leaps = leaps_r;
  assign doy   = doy_r;

endmodule

>>> hw/rtl/gdb_sum_unit.sv
// Two-stage combine: 365 * year span plus leap and doy differences; saturated, -1 if later.
// Depends on gdb_pkg.
module gdb_sum_unit (
  input  logic            clk,
  input  logic            en,
  input  gdb_pkg::year_t  year_span,
  input  logic            later,
  input  gdb_pkg::leaps_t leaps_s,
  input  gdb_pkg::leaps_t leaps_e,
  input  gdb_pkg::doy_t   doy_s,
  input  gdb_pkg::doy_t   doy_e,
  output gdb_pkg::count_t day_count,
  output logic            out_of_order
);

  logic [gdb_pkg::YD365_W-1:0]        yd365_r, yd365_nxt;
  logic signed [gdb_pkg::SMALL_W-1:0] small_r, small_nxt;
  logic                               later_r;
  logic signed [gdb_pkg::TOTAL_W-1:0] total;
  gdb_pkg::count_t                    count_r, count_nxt;
  logic                               ooo_r;

  assign yd365_nxt = gdb_pkg::YD365_W'(year_span) * gdb_pkg::YEAR_DAYS;
  assign small_nxt = $signed(gdb_pkg::SMALL_W'(leaps_e)) - $signed(gdb_pkg::SMALL_W'(leaps_s))
                   + $signed(gdb_pkg::SMALL_W'(doy_e)) - $signed(gdb_pkg::SMALL_W'(doy_s));

  always_ff @(posedge clk) begin
    if (en) begin
      yd365_r <= yd365_nxt;
      small_r <= small_nxt;
      later_r <= later;
    end
  end

  always_comb begin
    total = $signed({2'b00, yd365_r})
          + $signed({{(gdb_pkg::TOTAL_W-gdb_pkg::SMALL_W){small_r[gdb_pkg::SMALL_W-1]}},
                     small_r});
    if (later_r) begin
      count_nxt = '1;
    end else if (total > gdb_pkg::DC_MAX) begin
      count_nxt = gdb_pkg::DC_MAX[gdb_pkg::COUNT_W-1:0];
    end else if (total < gdb_pkg::DC_MIN) begin
      count_nxt = gdb_pkg::DC_MIN[gdb_pkg::COUNT_W-1:0];
    end else begin
      count_nxt = total[gdb_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r <= count_nxt;
      ooo_r   <= later_r;
    end
  end

  assign day_count    = count_r;
  assign out_of_order = ooo_r;

endmodule

>>> hw/rtl/gregorian_days_between_top.sv
// Throughput one date pair per cycle except while a full output waits on out_ready.
// Four register stages (reciprocal products, leap/day-of-year, span multiply, sum and
// saturate) advance together whenever the output register is empty or being taken.
// Reset (rst_n, synchronous, active low) clears the stage valid bits only.
// Depends on gdb_pkg, gdb_date_unit, gdb_sum_unit.
module gregorian_days_between_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gdb_pkg::year_t  in_start_year,
  input  gdb_pkg::month_t in_start_month,
  input  gdb_pkg::day_t   in_start_day,
  input  gdb_pkg::year_t  in_end_year,
  input  gdb_pkg::month_t in_end_month,
  input  gdb_pkg::day_t   in_end_day,
  output logic            out_valid,
  input  logic            out_ready,
  output gdb_pkg::count_t out_day_count,
  output logic            out_out_of_order
);

  logic en;
  logic [3:0] vld_r, vld_nxt;
  logic later_in;
  gdb_pkg::year_t span_in;
  gdb_pkg::year_t span_a_r, span_b_r;
  logic later_a_r, later_b_r;
  gdb_pkg::leaps_t leaps_s, leaps_e;
  gdb_pkg::doy_t doy_s, doy_e;

  // whole pipe moves as one; a stall freezes every stage
  assign en       = !vld_r[3] || out_ready;
  assign in_ready = en;
  assign vld_nxt  = {vld_r[2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign later_in = (in_start_year > in_end_year)
                 || ((in_start_year == in_end_year) && (in_start_month > in_end_month))
                 || ((in_start_year == in_end_year) && (in_start_month == in_end_month)
                     && (in_start_day > in_end_day));
  assign span_in  = in_end_year - in_start_year;

  always_ff @(posedge clk) begin
    if (en) begin
      span_a_r  <= span_in;
      later_a_r <= later_in;
      span_b_r  <= span_a_r;
      later_b_r <= later_a_r;
    end
  end

  gdb_date_unit u_start (
    .clk   (clk),
    .en    (en),
    .year  (in_start_year),
    .month (in_start_month),
    .day   (in_start_day),
    .leaps (leaps_s),
    .doy   (doy_s)
  );

  gdb_date_unit u_end (
    .clk   (clk),
    .en    (en),
    .year  (in_end_year),
    .month (in_end_month),
    .day   (in_end_day),
    .leaps (leaps_e),
    .doy   (doy_e)
  );

  gdb_sum_unit u_sum (
    .clk          (clk),
    .en           (en),
    .year_span    (span_b_r),
    .later        (later_b_r),
    .leaps_s      (leaps_s),
    .leaps_e      (leaps_e),
    .doy_s        (doy_s),
    .doy_e        (doy_e),
    .day_count    (out_day_count),
    .out_of_order (out_out_of_order)
  );

  assign out_valid = vld_r[3];

  a_ooo_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_order |-> out_day_count == '1)
    else $error("out-of-order beat without -1 count");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 in_ready ##1 in_ready ##1 in_ready |=> out_valid)
    else $error("accepted beat did not reach output after four free cycles");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
